// File: rtl/mltpq_pkg.sv
// Package for the multilevel timed priority queue core.
// Holds the action and status codes and the controller state type; no dependencies.
package mltpq_pkg;

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADLVL = 2'd3;

    localparam int ID_W   = 31;
    localparam int TIME_W = 32;
    localparam int LVL_W  = 4;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_SHIFTR = 7'b0000100,
        S_SHIFTW = 7'b0001000,
        S_PUT    = 7'b0010000,
        S_HEAD   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

endpackage

// File: rtl/multilevel_timed_priority_queue_core.sv
// Top level of the multilevel timed priority queue core.
// Depends on mltpq_pkg; holds the entry memory and the sequencer in one module.
//
//  channel | valid      | stall      | payload
//  input   | i_valid    | o_stall    | i_action, i_event_id, i_event_time, i_level
//  output  | o_valid    | i_stall    | o_status, o_out_id, o_out_time, o_out_level
//
// An insert reads the level's entries one per cycle from a single-port-read memory
// until it finds its place, then moves the entries behind that place up by one,
// each move a read followed by a write. Scanning and moving share the level's
// entries. An extract reads the head and moves the rest down the same way. Errors
// go straight to the output register. Reset clears the level counts at once; the
// entry memory needs no clearing. The result waits in an output register while
// i_stall is high, and no new item is taken until it leaves.
module multilevel_timed_priority_queue_core
    import mltpq_pkg::*;
#(
    parameter int NUM_LEVELS  = 8,
    parameter int LEVEL_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [ID_W-1:0]   i_event_id,
    input  logic [TIME_W-1:0] i_event_time,
    input  logic [LVL_W-1:0]  i_level,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_status,
    output logic [ID_W-1:0]   o_out_id,
    output logic [TIME_W-1:0] o_out_time,
    output logic [LVL_W-1:0]  o_out_level
);

    localparam int SW = $clog2(NUM_LEVELS);
    localparam int PW = $clog2(LEVEL_DEPTH);
    localparam int CW = $clog2(LEVEL_DEPTH + 1);
    localparam int AW = SW + PW;
    localparam int DW = ID_W + TIME_W;

    // Entry memory: id and time side by side, one word per entry.
    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] r_rdata;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_en;
    logic [DW-1:0] wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    logic [CW-1:0] r_cnt [NUM_LEVELS];
    t_state        r_state;
    logic          r_act;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_time;
    logic [SW-1:0]     r_slot;
    logic [CW-1:0]     r_pos;   // scan position, or index being moved
    logic [CW-1:0]     r_ccnt;  // count of the level being worked, or insertion place
    logic              r_ovalid;
    logic [1:0]        r_st;
    logic [ID_W-1:0]   r_oid;
    logic [TIME_W-1:0] r_otime;
    logic [LVL_W-1:0]  r_olvl;

    // Highest non-empty level, found by a priority search over the counts.
    logic          any_ne;
    logic [SW-1:0] top_slot;
    always_comb begin
        any_ne   = 1'b0;
        top_slot = '0;
        for (int s = 0; s < NUM_LEVELS; s++) begin
            if (r_cnt[s] != '0) begin
                any_ne   = 1'b1;
                top_slot = SW'(s);
            end
        end
    end

    logic accept;
    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign accept  = i_valid && !o_stall;

    logic         lvl_bad;
    logic [SW-1:0] in_slot;
    assign lvl_bad = (i_level == '0) || (32'(i_level) > NUM_LEVELS);
    assign in_slot = SW'(i_level - LVL_W'(1));

    function automatic logic [AW-1:0] mk_addr(logic [SW-1:0] s, logic [CW-1:0] p);
        return {s, p[PW-1:0]};
    endfunction

    always_comb begin
        rd_addr = mk_addr(r_slot, r_pos);
        wr_en   = 1'b0;
        wr_addr = mk_addr(r_slot, r_pos);
        wr_data = r_rdata;
        case (r_state)
            // An insert reads the head of its own level, an extract the head of the
            // highest non-empty level.
            S_IDLE:   rd_addr = (accept && i_action == ACT_INSERT) ? mk_addr(in_slot, '0)
                                                                   : mk_addr(top_slot, '0);
            S_SCAN:   rd_addr = mk_addr(r_slot, r_pos + CW'(1));
            S_SHIFTR: rd_addr = r_act ? mk_addr(r_slot, r_pos + CW'(1))
                                      : mk_addr(r_slot, r_pos - CW'(1));
            S_SHIFTW: wr_en = 1'b1;
            S_PUT: begin
                wr_en   = 1'b1;
                wr_data = {r_id, r_time};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int s = 0; s < NUM_LEVELS; s++) r_cnt[s] <= '0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (accept) begin
                    r_act  <= i_action;
                    r_id   <= i_event_id;
                    r_time <= i_event_time;
                    r_st   <= ST_OK;
                    r_oid  <= '0;
                    r_otime <= '0;
                    r_olvl <= '0;
                    r_pos  <= '0;
                    if (i_action == ACT_EXTRACT) begin
                        r_slot <= top_slot;
                        r_ccnt <= r_cnt[top_slot];
                        if (any_ne) r_state <= S_HEAD;
                        else begin
                            r_st    <= ST_EMPTY;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_slot <= in_slot;
                        if (lvl_bad) begin
                            r_st    <= ST_BADLVL;
                            r_state <= S_OUT;
                        end else if (32'(r_cnt[in_slot]) >= LEVEL_DEPTH) begin
                            r_st    <= ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            r_ccnt  <= r_cnt[in_slot];
                            r_state <= (r_cnt[in_slot] == '0) ? S_PUT : S_SCAN;
                        end
                    end
                end
                // r_rdata holds entry r_pos of the level.
                S_SCAN: begin
                    if (r_pos == '0 && r_rdata[TIME_W-1:0] > r_time) begin
                        r_pos   <= r_ccnt;
                        r_state <= S_SHIFTR;
                    end else if (r_pos != '0 && !(r_rdata[TIME_W-1:0] < r_time)) begin
                        r_id    <= r_id;
                        r_ccnt  <= r_pos;          // insertion place
                        r_pos   <= r_ccnt;
                        r_state <= (r_ccnt == r_pos) ? S_PUT : S_SHIFTR;
                    end else if (r_pos + CW'(1) == r_ccnt) begin
                        r_pos   <= r_ccnt;
                        r_ccnt  <= r_ccnt;
                        r_state <= S_PUT;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                    end
                    if (r_pos == '0 && r_rdata[TIME_W-1:0] > r_time) r_ccnt <= '0;
                end
                S_SHIFTR: r_state <= S_SHIFTW;
                // Insert: write entry r_pos-1 into r_pos. Extract: r_pos+1 into r_pos.
                S_SHIFTW: begin
                    if (r_act == ACT_INSERT) begin
                        r_pos   <= r_pos - CW'(1);
                        r_state <= (r_pos - CW'(1) == r_ccnt) ? S_PUT : S_SHIFTR;
                    end else if (r_pos + CW'(2) >= r_cnt[r_slot]) begin
                        r_cnt[r_slot] <= r_cnt[r_slot] - CW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_pos   <= r_pos + CW'(1);
                        r_state <= S_SHIFTR;
                    end
                end
                S_PUT: begin
                    r_cnt[r_slot] <= r_cnt[r_slot] + CW'(1);
                    r_state <= S_OUT;
                end
                S_HEAD: begin
                    r_oid   <= r_rdata[DW-1:TIME_W];
                    r_otime <= r_rdata[TIME_W-1:0];
                    r_olvl  <= LVL_W'(r_slot) + LVL_W'(1);
                    if (r_ccnt == CW'(1)) begin
                        r_cnt[r_slot] <= '0;
                        r_state <= S_OUT;
                    end else r_state <= S_SHIFTR;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_st;
    assign o_out_id    = r_oid;
    assign o_out_time  = r_otime;
    assign o_out_level = r_olvl;

endmodule

// File: sim/multilevel_timed_priority_queue_core_tb.sv
// Self-checking testbench for the multilevel timed priority queue core.
// Depends on mltpq_pkg and the core; an internal scheduler model predicts every result.
module multilevel_timed_priority_queue_core_tb;
    import mltpq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLEV   = 8;
    localparam int DEPTH  = 16;
    localparam int WD_LIM = 20000;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] tstamp;
        logic [LVL_W-1:0]  lvl;
    } sched_result_t;

    // Scoreboard: a behavioral copy of the scheduler plus a queue of pending results.
    class sched_scoreboard;
        logic [ID_W-1:0]   ids[NLEV][DEPTH];
        logic [TIME_W-1:0] times[NLEV][DEPTH];
        int                counts[NLEV];
        sched_result_t     pending[$];
        int                errors;

        function void clear();
            foreach (counts[i]) counts[i] = 0;
            pending.delete();
            errors = 0;
        endfunction

        // Work out the result of one accepted item and update the model.
        function void note_item(logic act, logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                                logic [LVL_W-1:0] lv);
            sched_result_t r;
            int s, pos, c;
            r = '0;
            if (act == ACT_INSERT) begin
                if (lv < 1 || lv > NLEV) begin
                    r.status = ST_BADLVL;
                end else if (counts[lv-1] >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    s = lv - 1;
                    c = counts[s];
                    // A new event lands behind an equal-time head, else ahead of equals.
                    if (c == 0 || times[s][0] > t) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < c && times[s][pos] < t) pos++;
                    end
                    for (int i = c; i > pos; i--) begin
                        ids[s][i] = ids[s][i-1];
                        times[s][i] = times[s][i-1];
                    end
                    ids[s][pos] = id;
                    times[s][pos] = t;
                    counts[s] = c + 1;
                    r.status = ST_OK;
                end
            end else begin
                r.status = ST_EMPTY;
                for (int l = NLEV; l > 0; l--) begin
                    if (r.status == ST_EMPTY && counts[l-1] != 0) begin
                        s = l - 1;
                        r.status = ST_OK;
                        r.id = ids[s][0];
                        r.tstamp = times[s][0];
                        r.lvl = LVL_W'(l);
                        for (int i = 0; i + 1 < counts[s]; i++) begin
                            ids[s][i] = ids[s][i+1];
                            times[s][i] = times[s][i+1];
                        end
                        counts[s]--;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
                errors++;
            end
            if (got.id !== exp.id) begin
                $display("%0t: out_id exp %h got %h", $time, exp.id, got.id);
                errors++;
            end
            if (got.tstamp !== exp.tstamp) begin
                $display("%0t: out_time exp %h got %h", $time, exp.tstamp, got.tstamp);
                errors++;
            end
            if (got.lvl !== exp.lvl) begin
                $display("%0t: out_level exp %0d got %0d", $time, exp.lvl, got.lvl);
                errors++;
            end
        endfunction
    endclass

    logic              clk, rst_n;
    logic              in_valid, out_stall;
    logic              act;
    logic [ID_W-1:0]   ev_id;
    logic [TIME_W-1:0] ev_time;
    logic [LVL_W-1:0]  ev_lvl;
    logic              res_valid;
    logic [1:0]        res_status;
    logic [ID_W-1:0]   res_id;
    logic [TIME_W-1:0] res_time;
    logic [LVL_W-1:0]  res_lvl;
    logic              dut_stall;

    sched_scoreboard sb;
    int  idle_cycles;
    bit  stall_quiet;

    multilevel_timed_priority_queue_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(dut_stall),
        .i_action(act), .i_event_id(ev_id), .i_event_time(ev_time), .i_level(ev_lvl),
        .o_valid(res_valid), .i_stall(out_stall),
        .o_status(res_status), .o_out_id(res_id), .o_out_time(res_time),
        .o_out_level(res_lvl)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Mostly short gaps, occasionally a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one item at the falling edge and hold it until it is taken. Valid
    // stays high into the next item when there is no gap.
    task automatic send_item(logic a, logic [ID_W-1:0] id, logic [TIME_W-1:0] t,
                             logic [LVL_W-1:0] lv, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        act      <= a;
        ev_id    <= id;
        ev_time  <= t;
        ev_lvl   <= lv;
        do @(posedge clk); while (dut_stall);
        sb.note_item(a, id, t, lv);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    function automatic logic [TIME_W-1:0] rand_time(bit narrow);
        if (narrow) return $urandom_range(0, 12);
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stall, check each accepted result at the rising edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_quiet) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && !out_stall) begin
            sb.check_result('{res_status, res_id, res_time, res_lvl});
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !dut_stall) || (res_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIM) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [TIME_W-1:0] t;
        int lv_pick;
        sb = new();
        sb.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        act = ACT_INSERT;
        ev_id = '0;
        ev_time = '0;
        ev_lvl = '0;
        out_stall = 1'b0;
        stall_quiet = 1'b0;
        idle_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Directed part: empty extract, bad levels, field extremes, equal-time ordering.
        send_item(ACT_EXTRACT, '1, '1, '1, 0);
        send_item(ACT_INSERT, 31'h1, 32'h5, 4'd0, 0);
        send_item(ACT_INSERT, 31'h2, 32'h5, 4'd9, 0);
        send_item(ACT_INSERT, 31'h3, 32'h5, 4'd15, 0);
        send_item(ACT_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd8, 0);
        send_item(ACT_INSERT, 31'h0, 32'h0, 4'd1, 0);
        // Equal head time, then equal entries further down the level.
        send_item(ACT_INSERT, 31'h10, 32'd20, 4'd3, 0);
        send_item(ACT_INSERT, 31'h11, 32'd20, 4'd3, 0);
        send_item(ACT_INSERT, 31'h12, 32'd30, 4'd3, 0);
        send_item(ACT_INSERT, 31'h13, 32'd30, 4'd3, 0);
        send_item(ACT_INSERT, 31'h14, 32'd10, 4'd3, 0);
        send_item(ACT_INSERT, 31'h15, 32'd20, 4'd3, 0);
        // Fill level 2 past its depth so the last inserts are dropped.
        for (int i = 0; i < DEPTH + 2; i++) begin
            send_item(ACT_INSERT, ID_W'($urandom), TIME_W'(DEPTH - i), 4'd2, 1);
        end
        // Drain all levels and one more to hit the empty case again.
        for (int i = 0; i < DEPTH + 9; i++) send_item(ACT_EXTRACT, '0, '0, '0, 0);

        // The sender holds off until every expected result is back.
        wait_drained();

        // Random part: phases weighted toward inserts or extracts, with narrow or wide times.
        for (int n = 0; n < 395; n++) begin
            if (n == 200) begin
                stall_quiet = 1'b1;
                wait_drained();
            end
            if (n == 260) stall_quiet = 1'b0;
            lv_pick = $urandom_range(0, 99);
            t = rand_time($urandom_range(0, 1));
            if ($urandom_range(0, 99) < ((n / 60) % 2 ? 35 : 60)) begin
                send_item(ACT_INSERT, ID_W'($urandom),
                          t, lv_pick < 6 ? 4'($urandom_range(9, 15)) :
                             lv_pick < 9 ? 4'd0 : 4'($urandom_range(1, NLEV)), 0);
            end else begin
                send_item(ACT_EXTRACT, ID_W'($urandom), t, 4'($urandom), 0);
            end
        end
        wait_drained();
        repeat (60) @(negedge clk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mltpq_pkg.sv
rtl/multilevel_timed_priority_queue_core.sv
sim/multilevel_timed_priority_queue_core_tb.sv
